// ===== hw/rtl/hteb_pkg.sv =====
package hteb_pkg;

  // Default table size and longest code that the table may hold.
  localparam int unsigned SymbolCount = 256;
  localparam int unsigned MaxCodeBits = 32;

  // Fixed field widths of the item channels.
  localparam int unsigned OpWidth    = 2;
  localparam int unsigned SymWidth   = 8;
  localparam int unsigned CodeWidth  = 32;
  localparam int unsigned LenWidth   = 6;
  localparam int unsigned ByteBits   = 8;

  // Bits held for one encode: up to seven pending bits plus a full code.
  localparam int unsigned TotalWidth = 6;
  localparam int unsigned WinWidth   = ByteBits + CodeWidth;
  localparam int unsigned ShiftWidth = $clog2(CodeWidth);

  typedef enum logic [OpWidth-1:0] {
    OP_LOAD   = 2'd0,
    OP_ENCODE = 2'd1,
    OP_FLUSH  = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_READ,
    ST_ALIGN,
    ST_MERGE,
    ST_FLUSH,
    ST_EMIT
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic ready;
    logic write;
    logic read;
    logic align;
    logic merge;
    logic flush;
    logic pop;
    logic finish;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic                  accept;
    logic [OpWidth-1:0]    op;
    logic                  len_zero;
    logic [TotalWidth-1:0] total;
    logic                  slot_free;
  } sts_t;

endpackage

// ===== hw/rtl/hteb_in_if.sv =====
interface hteb_in_if;
  import hteb_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [OpWidth-1:0]   operation;
  logic [SymWidth-1:0]  symbol;
  logic [CodeWidth-1:0] code_value;
  logic [LenWidth-1:0]  code_length;

  modport source (
    output valid, operation, symbol, code_value, code_length,
    input  ready
  );

  modport sink (
    input  valid, operation, symbol, code_value, code_length,
    output ready
  );

endinterface

// ===== hw/rtl/hteb_out_if.sv =====
interface hteb_out_if;
  import hteb_pkg::*;

  logic                valid;
  logic                ready;
  logic [ByteBits-1:0] packed_byte;
  logic                last_of_run;

  modport source (
    output valid, packed_byte, last_of_run,
    input  ready
  );

  modport sink (
    input  valid, packed_byte, last_of_run,
    output ready
  );

endinterface

// ===== hw/rtl/hteb_ram.sv =====
module hteb_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2,
  localparam int unsigned AddrWidth = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AddrWidth-1:0] waddr_i,
  input  logic [Width-1:0]     wdata_i,
  input  logic                 re_i,
  input  logic [AddrWidth-1:0] raddr_i,
  output logic [Width-1:0]     rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/hteb_ctrl.sv =====
module hteb_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  hteb_pkg::sts_t sts_i,
  output hteb_pkg::cmd_t cmd_o
);
  import hteb_pkg::*;

  state_e state_q, state_d;
  logic   total_ge_byte;
  logic   total_ge_two;

  assign total_ge_byte = (sts_i.total >= TotalWidth'(ByteBits));
  assign total_ge_two  = (sts_i.total >= TotalWidth'(2 * ByteBits));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (sts_i.accept) begin
          unique case (op_e'(sts_i.op))
            OP_LOAD:   state_d = ST_LOAD;
            OP_ENCODE: state_d = ST_READ;
            OP_FLUSH:  state_d = ST_FLUSH;
            default:   state_d = ST_IDLE;
          endcase
        end
      end
      ST_LOAD:  state_d = ST_IDLE;
      ST_READ:  state_d = ST_ALIGN;
      ST_ALIGN: state_d = sts_i.len_zero ? ST_IDLE : ST_MERGE;
      ST_MERGE: state_d = ST_EMIT;
      ST_FLUSH: state_d = ST_EMIT;
      ST_EMIT: begin
        if (!total_ge_byte || (sts_i.slot_free && !total_ge_two)) begin
          state_d = ST_IDLE;
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o        = '0;
    unique case (state_q)
      ST_IDLE:  cmd_o.ready = 1'b1;
      ST_LOAD:  cmd_o.write = 1'b1;
      ST_READ:  cmd_o.read  = 1'b1;
      ST_ALIGN: cmd_o.align = !sts_i.len_zero;
      ST_MERGE: cmd_o.merge = 1'b1;
      ST_FLUSH: cmd_o.flush = 1'b1;
      ST_EMIT: begin
        cmd_o.pop    = total_ge_byte && sts_i.slot_free;
        cmd_o.finish = !total_ge_byte || (sts_i.slot_free && !total_ge_two);
      end
      default:  cmd_o = '0;
    endcase
  end

endmodule

// ===== hw/rtl/hteb_dpath.sv =====
module hteb_dpath #(
  parameter int unsigned SYMBOL_COUNT  = hteb_pkg::SymbolCount,
  parameter int unsigned MAX_CODE_BITS = hteb_pkg::MaxCodeBits
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  hteb_in_if.sink         in_i,
  hteb_out_if.source      out_o,
  input  hteb_pkg::cmd_t  cmd_i,
  output hteb_pkg::sts_t  sts_o
);
  import hteb_pkg::*;

  localparam int unsigned AddrWidth   = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
  localparam int unsigned LenLimit    = (MAX_CODE_BITS < CodeWidth) ? MAX_CODE_BITS
                                                                     : CodeWidth;
  localparam int unsigned StLenWidth  = $clog2(LenLimit + 1);
  localparam int unsigned RamWidth    = CodeWidth + StLenWidth;
  localparam logic [SymWidth:0] SymLimit = (SymWidth + 1)'(SYMBOL_COUNT);

  // Captured item.
  logic [SymWidth-1:0]   sym_q;
  logic [CodeWidth-1:0]  cval_q;
  logic [LenWidth-1:0]   clen_q;

  // Table lookup and packing state.
  logic [SYMBOL_COUNT-1:0] valid_q;
  logic                    hit_q;
  logic [CodeWidth-1:0]    code_left_q;
  logic [TotalWidth-1:0]   total_q;
  logic [WinWidth-1:0]     win_q;
  logic [ByteBits-1:0]     acc_q;
  logic [2:0]              pending_q;

  // Output register.
  logic                out_valid_q, out_valid_d;
  logic [ByteBits-1:0] out_byte_q;
  logic                out_last_q;

  logic                    accept;
  logic                    in_range;
  logic [AddrWidth-1:0]    addr;
  logic [StLenWidth-1:0]   clen_sat;
  logic                    ram_we;
  logic [RamWidth-1:0]     ram_rdata;
  logic [CodeWidth-1:0]    rd_code;
  logic [StLenWidth-1:0]   len_eff;
  logic [LenWidth-1:0]     lsh;
  logic                    slot_free;

  assign accept    = in_i.valid && in_i.ready;
  assign in_i.ready = cmd_i.ready;

  assign in_range = ({1'b0, sym_q} < SymLimit);
  assign addr     = sym_q[AddrWidth-1:0];
  assign clen_sat = (clen_q > LenWidth'(LenLimit)) ? StLenWidth'(LenLimit)
                                                   : clen_q[StLenWidth-1:0];
  assign ram_we   = cmd_i.write && in_range;

  hteb_ram #(
    .Width (RamWidth),
    .Depth (SYMBOL_COUNT)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (addr),
    .wdata_i ({cval_q, clen_sat}),
    .re_i    (cmd_i.read),
    .raddr_i (addr),
    .rdata_o (ram_rdata)
  );

  assign rd_code = ram_rdata[RamWidth-1 -: CodeWidth];
  assign len_eff = hit_q ? ram_rdata[StLenWidth-1:0] : '0;
  assign lsh     = LenWidth'(CodeWidth) - LenWidth'(len_eff);

  assign slot_free   = !out_valid_q || out_o.ready;
  assign out_valid_d = cmd_i.pop || (out_valid_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      acc_q       <= '0;
      pending_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (ram_we) begin
        valid_q[addr] <= 1'b1;
      end
      // The accumulator is held left aligned, so the padding of a flush is
      // already in place.
      if (cmd_i.finish) begin
        acc_q     <= cmd_i.pop ? win_q[WinWidth-ByteBits-1 -: ByteBits]
                               : win_q[WinWidth-1 -: ByteBits];
        pending_q <= total_q[2:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sym_q  <= in_i.symbol;
      cval_q <= in_i.code_value;
      clen_q <= in_i.code_length;
    end
    if (cmd_i.read) begin
      hit_q <= in_range && valid_q[addr];
    end
    if (cmd_i.align) begin
      code_left_q <= rd_code << lsh[ShiftWidth-1:0];
      total_q     <= TotalWidth'(pending_q) + TotalWidth'(len_eff);
    end
    if (cmd_i.merge) begin
      win_q <= {acc_q, {CodeWidth{1'b0}}} | ({code_left_q, {ByteBits{1'b0}}} >> pending_q);
    end
    if (cmd_i.flush) begin
      win_q   <= {acc_q, {CodeWidth{1'b0}}};
      total_q <= (pending_q != '0) ? TotalWidth'(ByteBits) : '0;
    end
    if (cmd_i.pop) begin
      out_byte_q <= win_q[WinWidth-1 -: ByteBits];
      out_last_q <= (total_q < TotalWidth'(2 * ByteBits));
      win_q      <= win_q << ByteBits;
      total_q    <= total_q - TotalWidth'(ByteBits);
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.packed_byte = out_byte_q;
  assign out_o.last_of_run = out_last_q;

  assign sts_o.accept    = accept;
  assign sts_o.op        = in_i.operation;
  assign sts_o.len_zero  = (len_eff == '0);
  assign sts_o.total     = total_q;
  assign sts_o.slot_free = slot_free;

endmodule

// ===== hw/rtl/huffman_table_encoder_bit_packer_core.sv =====
// Channel   Direction  Payload                                          Item
// in_i      sink       operation, symbol, code_value, code_length       one command
// out_o     source     packed_byte, last_of_run                         one packed byte
//
// An item is taken only while the controller is idle. A load writes one table entry; a flush
// pads the pending bits. An encode reads the code table, aligns the code, merges it into the
// window and emits each whole byte, paced by the registered table read and the single
// byte-wide output register; an encode of an absent symbol ends after alignment. Reset
// clears the packer, the output register and the per-entry valid bits, so every table
// length reads zero at once. A stalled output only holds the controller in its emit state.
module huffman_table_encoder_bit_packer_core #(
  parameter int unsigned SYMBOL_COUNT  = hteb_pkg::SymbolCount,
  parameter int unsigned MAX_CODE_BITS = hteb_pkg::MaxCodeBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  hteb_in_if.sink     in_i,
  hteb_out_if.source  out_o
);
  import hteb_pkg::*;

  // The controller and the datapath talk only through these two bundles.
  cmd_t cmd;
  sts_t sts;

  // Sequencing of each item: idle, table access, alignment, merge, byte emission.
  hteb_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  // Code table, bit window and the output register.
  hteb_dpath #(
    .SYMBOL_COUNT  (SYMBOL_COUNT),
    .MAX_CODE_BITS (MAX_CODE_BITS)
  ) u_dpath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .out_o  (out_o),
    .cmd_i  (cmd),
    .sts_o  (sts)
  );

  // A byte is only ever taken from the window when a whole byte is there.
  a_pop_full_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.pop |-> (sts.total >= TotalWidth'(ByteBits)))
    else $error("byte emitted from a window holding fewer than eight bits");

  // Any meaningful command keeps the block busy in the following cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sts.accept && (sts.op == OP_LOAD || sts.op == OP_ENCODE || sts.op == OP_FLUSH))
    |=> !in_i.ready)
    else $error("new item taken while the previous one is still in progress");

  // Once the last byte is out the packer state is settled and the block is idle.
  a_idle_after_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |=> in_i.ready)
    else $error("controller not idle after finishing an item");

  // A symbol with a nonzero code length in the table always proceeds to the merge step.
  a_align_then_merge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.align |=> cmd.merge)
    else $error("aligned code not merged into the window");

endmodule

// ===== dv/huffman_table_encoder_bit_packer_core_tb.sv =====
module huffman_table_encoder_bit_packer_core_tb;
  import hteb_pkg::*;

  // Operation 3 has no meaning: the block must swallow it without a result.
  localparam logic [OpWidth-1:0] OpUnused = 2'd3;

  // The longest length that the table keeps. Larger loaded lengths are cut to it.
  localparam int unsigned LenLimit = (MaxCodeBits < CodeWidth) ? MaxCodeBits : CodeWidth;

  // Cycle limit for the whole run, with a wide margin over the slowest correct run.
  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned RandomItems  = 300;
  localparam int unsigned CalmItems    = 40;
  localparam int unsigned DrainCycles  = 20;
  localparam int unsigned ReportLimit  = 10;

  // Byte-level model of the encoder. It holds a copy of the code table and of the
  // packing register, and lists the bytes that each accepted command must produce.
  class byte_scoreboard;
    typedef struct packed {
      logic [ByteBits-1:0] value;
      logic                last;
    } packed_byte_t;

    logic [CodeWidth-1:0] code_tbl [SymbolCount];
    logic [LenWidth-1:0]  len_tbl  [SymbolCount];
    logic [ByteBits-1:0]  acc;
    int unsigned          pend_bits;
    packed_byte_t         due_q [$];
    int unsigned          mismatches;
    int unsigned          bytes_seen;
    int unsigned          loads, encodes, flushes, unused_ops;

    function new();
      foreach (len_tbl[i]) begin
        len_tbl[i]  = '0;
        code_tbl[i] = '0;
      end
      acc        = '0;
      pend_bits  = 0;
      mismatches = 0;
      bytes_seen = 0;
      loads      = 0;
      encodes    = 0;
      flushes    = 0;
      unused_ops = 0;
    endfunction

    function int unsigned outstanding();
      return due_q.size();
    endfunction

    // Called once for each command that the block has taken.
    function void note_command(logic [OpWidth-1:0] op, logic [SymWidth-1:0] sym,
                               logic [CodeWidth-1:0] cval, logic [LenWidth-1:0] clen);
      int unsigned  n_len;
      int unsigned  emitted;
      packed_byte_t b;
      emitted = 0;
      case (op)
        OP_LOAD: begin
          loads++;
          if (sym < SymbolCount) begin
            n_len = (clen > LenLimit) ? LenLimit : clen;
            code_tbl[sym] = cval;
            len_tbl[sym]  = n_len[LenWidth-1:0];
          end
        end
        OP_ENCODE: begin
          encodes++;
          if (sym < SymbolCount) begin
            // The code goes in most significant bit first; every eighth bit closes a byte.
            for (int i = int'(len_tbl[sym]); i > 0; i--) begin
              acc = {acc[ByteBits-2:0], code_tbl[sym][i-1]};
              pend_bits++;
              if (pend_bits == ByteBits) begin
                b.value = acc;
                b.last  = 1'b0;
                due_q.push_back(b);
                emitted++;
                acc       = '0;
                pend_bits = 0;
              end
            end
            if (emitted > 0) due_q[due_q.size()-1].last = 1'b1;
          end
        end
        OP_FLUSH: begin
          flushes++;
          if (pend_bits > 0) begin
            b.value = acc << (ByteBits - pend_bits);
            b.last  = 1'b1;
            due_q.push_back(b);
          end
          acc       = '0;
          pend_bits = 0;
        end
        default: unused_ops++;
      endcase
    endfunction

    // Called once for each byte that leaves the block.
    function void check_byte(logic [ByteBits-1:0] value, logic last);
      packed_byte_t want;
      bytes_seen++;
      if (due_q.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportLimit)
          $display("[%0t] unexpected byte %02h last %0b with nothing due", $time, value, last);
        return;
      end
      want = due_q.pop_front();
      if (want.value !== value || want.last !== last) begin
        mismatches++;
        if (mismatches <= ReportLimit)
          $display("[%0t] byte mismatch: expected %02h last %0b, got %02h last %0b",
                   $time, want.value, want.last, value, last);
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  hteb_in_if  in_if ();
  hteb_out_if out_if ();

  byte_scoreboard sb;

  // Set for the closing stretch of the run, when neither side idles.
  logic        calm;
  int unsigned stall_left;
  int unsigned cycle_count;

  // Symbols that have been given a nonzero length, so that most encodes find a code.
  logic [SymWidth-1:0] present_q [$];

  huffman_table_encoder_bit_packer_core u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #5 clk_i = ~clk_i;

  // Every input starts from a known value before the first clock edge.
  initial begin
    clk_i              = 1'b0;
    rst_ni             = 1'b0;
    calm               = 1'b0;
    stall_left         = 0;
    cycle_count        = 0;
    in_if.valid        = 1'b0;
    in_if.operation    = OP_LOAD;
    in_if.symbol       = '0;
    in_if.code_value   = '0;
    in_if.code_length  = '0;
    out_if.ready       = 1'b0;
    sb                 = new();
  end

  // Back-pressure on the byte output: ready drops in random bursts, so
  // stalls land on the first, middle and last byte of a multi-byte encode alike.
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left   <= stall_left - 1;
      out_if.ready <= 1'b0;
    end else if (!calm && rst_ni && $urandom_range(0, 5) == 0) begin
      stall_left   <= $urandom_range(1, 13) - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // Bytes are taken at the edge where valid and ready were both high beforehand.
  // The design updates its outputs through nonblocking assignments, so the values
  // read here are those that held just before the edge.
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready)
      sb.check_byte(out_if.packed_byte, out_if.last_of_run);
  end

  // Offers one command and returns at the edge where the block takes it. Valid
  // stays high from one command to the next unless an idle burst comes between
  // them, so it never gets two assignments at the same edge.
  task automatic send_command(logic [OpWidth-1:0] op, logic [SymWidth-1:0] sym,
                              logic [CodeWidth-1:0] cval, logic [LenWidth-1:0] clen);
    int unsigned gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 13);
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.operation   <= op;
    in_if.symbol      <= sym;
    in_if.code_value  <= cval;
    in_if.code_length <= clen;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_command(op, sym, cval, clen);
    if (op == OP_LOAD && clen != 0) present_q.push_back(sym);
  endtask

  // One random command. Most are loads and encodes of symbols that hold a code;
  // the rest are flushes, absent or overlong entries and the unused operation.
  task automatic send_random_command();
    int unsigned         pick;
    int unsigned         len_pick;
    logic [SymWidth-1:0] sym;
    logic [LenWidth-1:0] clen;
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      len_pick = $urandom_range(0, 9);
      if (len_pick < 5)       clen = LenWidth'($urandom_range(1, 8));
      else if (len_pick < 8)  clen = LenWidth'($urandom_range(9, 32));
      else if (len_pick == 8) clen = '0;
      else                    clen = LenWidth'($urandom_range(33, 63));
      send_command(OP_LOAD, SymWidth'($urandom_range(0, 255)), $urandom, clen);
    end else if (pick < 82) begin
      if (present_q.size() > 0 && $urandom_range(0, 9) != 0)
        sym = present_q[$urandom_range(0, present_q.size() - 1)];
      else
        sym = SymWidth'($urandom_range(0, 255));
      send_command(OP_ENCODE, sym, $urandom, LenWidth'($urandom_range(0, 63)));
    end else if (pick < 94) begin
      send_command(OP_FLUSH, SymWidth'($urandom_range(0, 255)), $urandom,
                   LenWidth'($urandom_range(0, 63)));
    end else begin
      send_command(OpUnused, SymWidth'($urandom_range(0, 255)), $urandom,
                   LenWidth'($urandom_range(0, 63)));
    end
  endtask

  // A hung handshake ends the run here.
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. The table is empty after reset, so the first encode must
    // produce nothing; a flush with nothing pending and the unused operation too.
    send_command(OP_ENCODE, 8'h00, 32'h0, 6'd0);
    send_command(OP_FLUSH,  8'h00, 32'h0, 6'd0);
    send_command(OpUnused,  8'hFF, 32'hFFFF_FFFF, 6'd63);

    // The longest code, a one-bit code, a short one, an overlong length that is
    // cut down to the limit, and an entry loaded as absent.
    send_command(OP_LOAD, 8'h00, 32'hFFFF_FFFF, 6'd32);
    send_command(OP_LOAD, 8'hFF, 32'h0000_0000, 6'd1);
    send_command(OP_LOAD, 8'hAA, 32'h0000_0005, 6'd3);
    send_command(OP_LOAD, 8'h55, 32'hA5A5_A5A5, 6'd63);
    send_command(OP_LOAD, 8'h01, 32'hDEAD_BEEF, 6'd0);

    // One pending bit plus a full 32-bit code gives the most bytes one item can make.
    send_command(OP_ENCODE, 8'hFF, 32'h0, 6'd0);
    send_command(OP_ENCODE, 8'h00, 32'h0, 6'd0);
    send_command(OP_ENCODE, 8'h55, 32'h0, 6'd0);
    send_command(OP_ENCODE, 8'h01, 32'h0, 6'd0);
    send_command(OP_ENCODE, 8'hAA, 32'h0, 6'd0);
    // Pending bits are padded with zeros; a second flush finds nothing to send.
    send_command(OP_FLUSH,  8'h00, 32'h0, 6'd0);
    send_command(OP_FLUSH,  8'h00, 32'h0, 6'd0);

    // A code of exactly one byte on an empty packer, then a length one past the limit.
    send_command(OP_LOAD,   8'h02, 32'h0000_00FF, 6'd8);
    send_command(OP_ENCODE, 8'h02, 32'h0, 6'd0);
    send_command(OP_LOAD,   8'h03, 32'h1234_5678, 6'd33);
    send_command(OP_ENCODE, 8'h03, 32'h0, 6'd0);
    send_command(OP_ENCODE, 8'hFF, 32'h0, 6'd0);
    send_command(OP_ENCODE, 8'h03, 32'h0, 6'd0);
    // Loading a length of zero over a live entry makes it absent again.
    send_command(OP_LOAD,   8'h00, 32'h0000_0000, 6'd0);
    send_command(OP_ENCODE, 8'h00, 32'h0, 6'd0);
    send_command(OP_FLUSH,  8'h00, 32'h0, 6'd0);

    // Random part; the closing stretch runs with no idling on either side.
    for (int unsigned n = 0; n < RandomItems; n++) begin
      if (n == RandomItems - CalmItems) calm <= 1'b1;
      send_random_command();
    end
    send_command(OP_FLUSH, 8'h00, 32'h0, 6'd0);
    in_if.valid <= 1'b0;

    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d loads, %0d encodes, %0d flushes and %0d unused commands.",
             sb.loads, sb.encodes, sb.flushes, sb.unused_ops);
    $display("Checked %0d packed bytes; %0d mismatches.", sb.bytes_seen, sb.mismatches);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/hteb_pkg.sv
hw/rtl/hteb_in_if.sv
hw/rtl/hteb_out_if.sv
hw/rtl/hteb_ram.sv
hw/rtl/hteb_ctrl.sv
hw/rtl/hteb_dpath.sv
hw/rtl/huffman_table_encoder_bit_packer_core.sv
dv/huffman_table_encoder_bit_packer_core_tb.sv
